/* hdl/mlfq_tick_scheduler_top_defines.svh */
// ----------------------------------------------------------------------------
// mlfq_tick_scheduler_top_defines.svh
// Assertion macros shared by the scheduler RTL. Each macro expects signals
// named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MLFQ_TICK_SCHEDULER_TOP_DEFINES_SVH
`define MLFQ_TICK_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define MLFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define MLFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mlfq_pkg.sv */
// ----------------------------------------------------------------------------
// mlfq_pkg
// Types, codes and constants shared by the feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // Default sizing
  localparam int TASKS_DEF  = 16;
  localparam int LEVELS_DEF = 3;

  // Fixed field widths
  localparam int ID_W      = 4;
  localparam int BURST_W   = 16;
  localparam int QUANT_W   = 8;
  localparam int TIME_W    = 32;
  localparam int OUT_LVL_W = 2;

  // APB register port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Quantum reset values
  localparam logic [QUANT_W-1:0] QUANTUM_TOP_RST    = 8'd2;
  localparam logic [QUANT_W-1:0] QUANTUM_MIDDLE_RST = 8'd4;
  localparam logic [QUANT_W-1:0] QUANTUM_BOTTOM_RST = 8'd8;

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_TICK_IDLE = 2'd2,
    ST_RAN       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_QTOP    = 2'd0,
    REG_QMIDDLE = 2'd1,
    REG_QBOTTOM = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLOT,
    S_BURST,
    S_OUT
  } sched_state_t;

  typedef struct packed {
    op_t                operation;
    logic [ID_W-1:0]    task_id;
    logic [BURST_W-1:0] burst;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [ID_W-1:0]      ran_task;
    logic                 finished;
    logic                 demoted;
    logic [OUT_LVL_W-1:0] new_level;
    logic [TIME_W-1:0]    time_now;
  } out_item_t;

  // Quantum settings handed from the register block to the scheduler
  typedef struct packed {
    logic [QUANT_W-1:0] top;
    logic [QUANT_W-1:0] middle;
    logic [QUANT_W-1:0] bottom;
  } quanta_t;

endpackage

/* hdl/mlfq_tick_scheduler_top.sv */
// ----------------------------------------------------------------------------
// mlfq_tick_scheduler_top
// Multilevel feedback queue scheduler driven by arrival and tick transactions.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time and returns exactly one result
// for each. An arrival or a tick with nothing queued or running goes straight
// to the output state S_OUT. A tick of an already running task passes through
// S_BURST first, and a tick that first dispatches a queued task through S_SLOT
// and then S_BURST: the head is read from the queue slot RAM, then the task's
// remaining burst from the burst RAM, each a registered read, before the burst
// is written back. The output state waits on out_ready. No clearing pass follows
// reset; queues and bursts are only read where they were written before.
`include "mlfq_tick_scheduler_top_defines.svh"

module mlfq_tick_scheduler_top
  import mlfq_pkg::*;
#(
  parameter int TASKS  = TASKS_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  // APB register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int TW  = $clog2(TASKS);
  localparam int CW  = $clog2(TASKS + 1);
  localparam int LW  = $clog2(LEVELS);
  localparam int QD  = LEVELS * TASKS;
  localparam int QAW = $clog2(QD);

  // Slot address of position pos in the circular queue of level lvl
  function automatic logic [QAW-1:0] qaddr(input logic [LW-1:0] lvl,
                                           input logic [TW-1:0] pos);
    return QAW'(lvl) * QAW'(TASKS) + QAW'(pos);
  endfunction

  // Quantum for a level; a zero setting acts as one
  function automatic logic [QUANT_W-1:0] level_quantum(input logic [LW-1:0] lvl,
                                                       input quanta_t q);
    logic [QUANT_W-1:0] v;
    if (lvl == '0) begin
      v = q.top;
    end else if (lvl >= LW'(LEVELS - 1)) begin
      v = q.bottom;
    end else begin
      v = q.middle;
    end
    return (v == '0) ? QUANT_W'(1) : v;
  endfunction

  // Control state
  sched_state_t       state_r, state_nxt;
  logic [TASKS-1:0]   active_r, active_nxt;
  logic [TW-1:0]      head_r  [LEVELS];
  logic [TW-1:0]      head_nxt [LEVELS];
  logic [CW-1:0]      count_r [LEVELS];
  logic [CW-1:0]      count_nxt [LEVELS];
  logic [TW-1:0]      cur_task_r, cur_task_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [LW-1:0]      cur_level_r, cur_level_nxt;
  logic [QUANT_W-1:0] slice_r, slice_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload
  out_item_t          res_r, res_nxt;
  out_item_t          out_data_r;

  // Memory ports
  logic               burst_we;
  logic [TW-1:0]      burst_waddr, burst_raddr;
  logic [BURST_W-1:0] burst_wdata, burst_rdata;
  logic               slot_we;
  logic [QAW-1:0]     slot_waddr, slot_raddr;
  logic [TW-1:0]      slot_wdata, slot_rdata;

  // Datapath helpers
  quanta_t            quanta;
  logic               in_fire, out_free;
  logic [TW-1:0]      id_idx;
  logic               id_ok, arr_ok;
  logic               any_ready;
  logic [LW-1:0]      sel_lvl, next_lvl, lvl_pick;
  logic [TW-1:0]      pick_head, pick_head_inc, pick_tail;
  logic [CW-1:0]      pick_count;
  logic [TW:0]        tail_sum;
  logic [BURST_W-1:0] rem;
  logic [QUANT_W-1:0] slice_dec;

  // Register block
  mlfq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quanta  (quanta)
  );

  // Remaining burst per task
  mlfq_ram #(
    .WIDTH (BURST_W),
    .DEPTH (TASKS)
  ) u_burst_ram (
    .clk   (clk),
    .we    (burst_we),
    .waddr (burst_waddr),
    .wdata (burst_wdata),
    .raddr (burst_raddr),
    .rdata (burst_rdata)
  );

  // Circular queue slots, one row of TASKS entries per level
  mlfq_ram #(
    .WIDTH (TW),
    .DEPTH (QD)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Handshakes
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Arrival checks
  assign id_idx = TW'(in_data.task_id);
  assign id_ok  = int'(in_data.task_id) < TASKS;
  assign arr_ok = id_ok && !active_r[id_idx] && (in_data.burst != '0) &&
                  (pick_count < CW'(TASKS));

  // Highest non-empty level
  always_comb begin
    sel_lvl   = '0;
    any_ready = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (count_r[l] != '0) begin
        sel_lvl   = LW'(l);
        any_ready = 1'b1;
      end
    end
  end

  // Demotion target, clamped at the bottom level
  assign next_lvl = (cur_level_r == LW'(LEVELS - 1)) ? cur_level_r
                                                     : cur_level_r + LW'(1);

  // One queue touched per cycle: pop level on dispatch, demotion level on
  // requeue, top level on arrival
  always_comb begin
    case (state_r)
      S_IDLE:  lvl_pick = (in_data.operation == OP_TICK) ? sel_lvl : '0;
      S_BURST: lvl_pick = next_lvl;
      default: lvl_pick = '0;
    endcase
  end

  assign pick_head     = head_r[lvl_pick];
  assign pick_count    = count_r[lvl_pick];
  assign pick_head_inc = (pick_head == TW'(TASKS - 1)) ? '0 : pick_head + TW'(1);
  assign tail_sum      = (TW + 1)'(pick_head) + (TW + 1)'(pick_count);
  assign pick_tail     = (tail_sum >= (TW + 1)'(TASKS)) ?
                         TW'(tail_sum - (TW + 1)'(TASKS)) : TW'(tail_sum);

  assign rem       = burst_rdata - BURST_W'(1);
  assign slice_dec = slice_r - QUANT_W'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.operation == OP_ARRIVAL) begin
            state_nxt = S_OUT;
          end else if (cur_valid_r) begin
            state_nxt = S_BURST;
          end else if (any_ready) begin
            state_nxt = S_SLOT;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SLOT:  state_nxt = S_BURST;
      S_BURST: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    active_nxt    = active_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    cur_task_nxt  = cur_task_r;
    cur_valid_nxt = cur_valid_r;
    cur_level_nxt = cur_level_r;
    slice_nxt     = slice_r;
    time_nxt      = time_r;
    res_nxt       = res_r;
    burst_we      = 1'b0;
    burst_waddr   = cur_task_r;
    burst_wdata   = rem;
    burst_raddr   = cur_task_r;
    slot_we       = 1'b0;
    slot_waddr    = qaddr(lvl_pick, pick_tail);
    slot_wdata    = cur_task_r;
    slot_raddr    = qaddr(lvl_pick, pick_head);

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt.ran_task  = '0;
          res_nxt.finished  = 1'b0;
          res_nxt.demoted   = 1'b0;
          res_nxt.new_level = '0;
          res_nxt.time_now  = time_r;
          if (in_data.operation == OP_ARRIVAL) begin
            // Append to the top queue
            res_nxt.status = arr_ok ? ST_ACCEPTED : ST_REJECTED;
            if (arr_ok) begin
              active_nxt[id_idx]  = 1'b1;
              burst_we            = 1'b1;
              burst_waddr         = id_idx;
              burst_wdata         = in_data.burst;
              slot_we             = 1'b1;
              slot_wdata          = id_idx;
              count_nxt[lvl_pick] = pick_count + CW'(1);
            end
          end else if (!cur_valid_r) begin
            if (any_ready) begin
              // Pop the head; slot data arrives next cycle
              head_nxt[lvl_pick]  = pick_head_inc;
              count_nxt[lvl_pick] = pick_count - CW'(1);
              cur_level_nxt       = lvl_pick;
            end else begin
              time_nxt         = time_r + TIME_W'(1);
              res_nxt.status   = ST_TICK_IDLE;
              res_nxt.time_now = time_r + TIME_W'(1);
            end
          end
        end
      end

      S_SLOT: begin
        // Dispatch the popped task with its level's quantum
        cur_task_nxt  = slot_rdata;
        cur_valid_nxt = 1'b1;
        slice_nxt     = level_quantum(cur_level_r, quanta);
        burst_raddr   = slot_rdata;
      end

      S_BURST: begin
        // Run one tick: write back the burst, then finish, demote or keep running
        burst_we          = 1'b1;
        slice_nxt         = slice_dec;
        time_nxt          = time_r + TIME_W'(1);
        res_nxt.status    = ST_RAN;
        res_nxt.ran_task  = ID_W'(cur_task_r);
        res_nxt.finished  = 1'b0;
        res_nxt.demoted   = 1'b0;
        res_nxt.new_level = '0;
        res_nxt.time_now  = time_r + TIME_W'(1);
        if (rem == '0) begin
          res_nxt.finished       = 1'b1;
          active_nxt[cur_task_r] = 1'b0;
          cur_valid_nxt          = 1'b0;
        end else if (slice_dec == '0) begin
          slot_we             = 1'b1;
          count_nxt[lvl_pick] = pick_count + CW'(1);
          cur_valid_nxt       = 1'b0;
          res_nxt.demoted     = 1'b1;
          res_nxt.new_level   = OUT_LVL_W'(next_lvl);
        end
      end

      default: begin
      end
    endcase
  end

  // Output register
  assign out_valid_nxt = (state_r == S_OUT) || (out_valid_r && !out_ready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      head_r      <= '{default: '0};
      count_r     <= '{default: '0};
      cur_task_r  <= '0;
      cur_valid_r <= 1'b0;
      cur_level_r <= '0;
      slice_r     <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cur_task_r  <= cur_task_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_level_r <= cur_level_nxt;
      slice_r     <= slice_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == S_OUT && out_free) begin
      out_data_r <= res_r;
    end
  end

  // Checks
  `MLFQ_ASSERT_NOW(a_cur_task_active, cur_valid_r, active_r[cur_task_r],
    "running task is not marked active")
  `MLFQ_ASSERT_NOW(a_burst_needs_task, state_r == S_BURST, cur_valid_r,
    "burst update without a running task")
  `MLFQ_ASSERT_NOW(a_result_rise, $rose(out_valid_r), $past(state_r == S_OUT),
    "result raised outside the output state")
  `MLFQ_ASSERT_NOW(a_fin_xor_dem, out_valid_r,
    !(out_data_r.finished && out_data_r.demoted),
    "result both finished and demoted")
  `MLFQ_ASSERT_NEXT(a_slot_then_burst, state_r == S_SLOT,
    state_r == S_BURST && cur_valid_r, "dispatch did not reach burst update")

endmodule

/* hdl/mlfq_ram.sv */
// ----------------------------------------------------------------------------
// mlfq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/mlfq_cfg.sv */
// ----------------------------------------------------------------------------
// mlfq_cfg
// APB register block holding the three per-level quantum settings.
// ----------------------------------------------------------------------------
module mlfq_cfg
  import mlfq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output quanta_t           quanta
);

  quanta_t  quanta_r, quanta_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign quanta = quanta_r;

  // Register write decode; the unused word is ignored
  always_comb begin
    quanta_nxt = quanta_r;
    if (wr_en) begin
      case (idx)
        REG_QTOP:    quanta_nxt.top    = pwdata[QUANT_W-1:0];
        REG_QMIDDLE: quanta_nxt.middle = pwdata[QUANT_W-1:0];
        REG_QBOTTOM: quanta_nxt.bottom = pwdata[QUANT_W-1:0];
        default:     quanta_nxt        = quanta_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quanta_r.top    <= QUANTUM_TOP_RST;
      quanta_r.middle <= QUANTUM_MIDDLE_RST;
      quanta_r.bottom <= QUANTUM_BOTTOM_RST;
    end else begin
      quanta_r <= quanta_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_QTOP:    prdata = CFG_DW'(quanta_r.top);
      REG_QMIDDLE: prdata = CFG_DW'(quanta_r.middle);
      REG_QBOTTOM: prdata = CFG_DW'(quanta_r.bottom);
      default:     prdata = '0;
    endcase
  end

endmodule
